[sv/swd_ts_pkg.sv]
// ----------------------------------------------------------------------------
// SWD transfer sequencer package
// Shared codes, event and result records, and queue depths.
// ----------------------------------------------------------------------------
package swd_ts_pkg;

	// Queue depths (powers of two; the result queue needs at least two slots)
	localparam int unsigned EVQ_DEPTH  = 2;
	localparam int unsigned RESQ_DEPTH = 4;

	// Request byte bit positions
	localparam int unsigned REQ_AP_BIT    = 0;
	localparam int unsigned REQ_READ_BIT  = 1;
	localparam int unsigned REQ_MVAL_BIT  = 4;
	localparam int unsigned REQ_MMASK_BIT = 5;

	// Read of the DP read buffer: read bit plus address 3
	localparam logic [3:0] RDBUFF_NIBBLE = 4'hE;

	typedef enum logic [1:0] {
		OP_BEGIN = 2'd0,
		OP_REQ   = 2'd1,
		OP_END   = 2'd2,
		OP_ACK   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ACK_OK    = 2'd0,
		ACK_WAIT  = 2'd1,
		ACK_FAULT = 2'd2,
		ACK_ERR   = 2'd3
	} ack_t;

	typedef enum logic [1:0] {
		KIND_CMD    = 2'd0,
		KIND_WORD   = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_READY = 3'd1,
		PH_DRAIN = 3'd2,
		PH_CMD   = 3'd3,
		PH_FINAL = 3'd4,
		PH_ABORT = 3'd5
	} phase_t;

	// Classified input event
	typedef struct packed {
		op_t         op;
		logic        ap;
		logic        rd;
		logic        mval;
		logic        mmask;
		logic [7:0]  req;
		logic [31:0] wdata;
		ack_t        ack;
		logic [31:0] rdata;
	} ev_t;

	// One result beat
	typedef struct packed {
		kind_t       kind;
		logic [3:0]  wire_request;
		logic        want_read_data;
		logic [31:0] data_word;
		logic [7:0]  completed;
		ack_t        status_ack;
		logic        last;
	} res_t;

	// Up to two results handed to the result queue in one cycle
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} res_push_t;

endpackage

[sv/swd_ts_if.sv]
// ----------------------------------------------------------------------------
// SWD transfer sequencer channels
// Valid/ready channels for input events and result beats.
// ----------------------------------------------------------------------------
interface swd_ts_evt_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [7:0]  request_byte;
	logic [31:0] write_data;
	logic [1:0]  wire_ack;
	logic [31:0] read_data;

	modport source (output valid, op, request_byte, write_data, wire_ack, read_data,
		input ready);
	modport sink (input valid, op, request_byte, write_data, wire_ack, read_data,
		output ready);
endinterface

interface swd_ts_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [3:0]  wire_request;
	logic        want_read_data;
	logic [31:0] data_word;
	logic [7:0]  completed;
	logic [1:0]  status_ack;
	logic        last;

	modport source (output valid, kind, wire_request, want_read_data, data_word,
		completed, status_ack, last, input ready);
	modport sink (input valid, kind, wire_request, want_read_data, data_word,
		completed, status_ack, last, output ready);
endinterface

[sv/swd_ts_front.sv]
// ----------------------------------------------------------------------------
// SWD transfer sequencer front end
// Accepts input beats, decodes the request byte and queues the events.
// ----------------------------------------------------------------------------
module swd_ts_front #(
	parameter int unsigned DEPTH = swd_ts_pkg::EVQ_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	swd_ts_evt_if.sink      evt,
	output logic            hd_valid,
	output swd_ts_pkg::ev_t hd,
	input  logic            pop
);
	import swd_ts_pkg::*;

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	ev_t           mem_q [DEPTH];
	ev_t           ev;
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          push;
	logic          do_pop;

	// Classify the incoming beat
	always_comb begin
		ev.op    = op_t'(evt.op);
		ev.ap    = evt.request_byte[REQ_AP_BIT];
		ev.rd    = evt.request_byte[REQ_READ_BIT];
		ev.mval  = evt.request_byte[REQ_MVAL_BIT];
		ev.mmask = evt.request_byte[REQ_MMASK_BIT];
		ev.req   = evt.request_byte;
		ev.wdata = evt.write_data;
		ev.ack   = ack_t'(evt.wire_ack);
		ev.rdata = evt.read_data;
	end

	assign evt.ready = (cnt_q != CW'(DEPTH));
	assign push      = evt.valid && evt.ready;
	assign hd_valid  = (cnt_q != '0);
	assign do_pop    = pop && hd_valid;
	assign hd        = mem_q[rd_ptr_q];

	// Store queued events
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= ev;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[sv/swd_ts_exec.sv]
// ----------------------------------------------------------------------------
// SWD transfer sequencer back end
// Runs the packet state machine on queued events and emits result beats.
// ----------------------------------------------------------------------------
module swd_ts_exec (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  hd_valid,
	input  swd_ts_pkg::ev_t       hd,
	output logic                  pop,
	input  logic                  room,
	input  logic [15:0]           retry_limit,
	output swd_ts_pkg::res_push_t push
);
	import swd_ts_pkg::*;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_BEGIN,
		ACT_REJECT,
		ACT_MASK,
		ACT_ISSUE_DRAIN,
		ACT_ISSUE_CMD,
		ACT_ISSUE_FINAL,
		ACT_STATUS,
		ACT_RETRY,
		ACT_FAIL,
		ACT_DRAIN_OK,
		ACT_CMD_OK,
		ACT_FINAL_OK
	} act_t;

	phase_t      phase_q, phase_d;
	logic        posted_q, posted_d;
	logic        wpend_q, wpend_d;
	logic [7:0]  done_q, done_d;
	logic [15:0] retries_q, retries_d;
	logic [7:0]  held_q, held_d;
	logic [31:0] hdata_q, hdata_d;
	logic [31:0] mask_q, mask_d;
	ack_t        cack_q, cack_d;
	act_t        act;
	logic        fire;
	logic        busy;
	res_push_t   rp;

	// Wire command for a busy phase
	function automatic res_t cmd_res(phase_t ph, logic [7:0] req, logic [31:0] data,
		logic posted);
		res_t r;
		r = '0;
		r.kind = KIND_CMD;
		if (ph == PH_DRAIN) begin
			r.wire_request   = RDBUFF_NIBBLE;
			r.want_read_data = 1'b1;
		end else if (ph == PH_FINAL) begin
			r.wire_request   = RDBUFF_NIBBLE;
			r.want_read_data = posted;
		end else if (req[REQ_READ_BIT]) begin
			r.wire_request   = req[3:0];
			r.want_read_data = !(req[REQ_AP_BIT] && !posted);
		end else begin
			r.wire_request = req[3:0];
			r.data_word    = data;
		end
		return r;
	endfunction

	function automatic res_t word_res(logic [31:0] w);
		res_t r;
		r = '0;
		r.kind      = KIND_WORD;
		r.data_word = w;
		return r;
	endfunction

	function automatic res_t status_res(logic [7:0] cnt, ack_t a);
		res_t r;
		r = '0;
		r.kind       = KIND_STATUS;
		r.completed  = cnt;
		r.status_ack = a;
		return r;
	endfunction

	assign fire = hd_valid && room;
	assign pop  = fire;
	assign busy = (phase_q == PH_DRAIN) || (phase_q == PH_CMD) || (phase_q == PH_FINAL);

	// Decide the action for the head event
	always_comb begin
		act = ACT_NONE;
		unique case (hd.op)
			OP_BEGIN: act = ACT_BEGIN;
			OP_REQ: begin
				if (phase_q == PH_READY) begin
					priority if (hd.mval)                      act = ACT_REJECT;
					else if (!hd.rd && hd.mmask)               act = ACT_MASK;
					else if (posted_q && !(hd.rd && hd.ap))    act = ACT_ISSUE_DRAIN;
					else                                       act = ACT_ISSUE_CMD;
				end
			end
			OP_END: begin
				if (phase_q == PH_READY && (posted_q || wpend_q)) begin
					act = ACT_ISSUE_FINAL;
				end else if (phase_q == PH_READY || phase_q == PH_IDLE ||
					phase_q == PH_ABORT) begin
					act = ACT_STATUS;
				end
			end
			OP_ACK: begin
				if (busy) begin
					priority if (hd.ack == ACK_WAIT && retries_q != '0) act = ACT_RETRY;
					else if (hd.ack != ACK_OK)                          act = ACT_FAIL;
					else if (phase_q == PH_DRAIN)                       act = ACT_DRAIN_OK;
					else if (phase_q == PH_CMD)                         act = ACT_CMD_OK;
					else                                                act = ACT_FINAL_OK;
				end
			end
			default: act = ACT_NONE;
		endcase
	end

	// Next state
	always_comb begin
		phase_d   = phase_q;
		posted_d  = posted_q;
		wpend_d   = wpend_q;
		done_d    = done_q;
		retries_d = retries_q;
		held_d    = held_q;
		hdata_d   = hdata_q;
		mask_d    = mask_q;
		cack_d    = cack_q;
		if (act == ACT_MASK || act == ACT_ISSUE_DRAIN || act == ACT_ISSUE_CMD) begin
			held_d  = hd.req;
			hdata_d = hd.wdata;
			if (hd.rd) begin
				wpend_d = 1'b0;
			end
		end
		unique case (act)
			ACT_BEGIN: begin
				phase_d  = PH_READY;
				posted_d = 1'b0;
				wpend_d  = 1'b0;
				done_d   = '0;
				cack_d   = ACK_OK;
			end
			ACT_REJECT: begin
				cack_d  = ACK_ERR;
				phase_d = PH_ABORT;
			end
			ACT_MASK: begin
				mask_d = hd.wdata;
				done_d = done_q + 8'd1;
			end
			ACT_ISSUE_DRAIN: begin
				phase_d   = PH_DRAIN;
				retries_d = retry_limit;
			end
			ACT_ISSUE_CMD: begin
				phase_d   = PH_CMD;
				retries_d = retry_limit;
			end
			ACT_ISSUE_FINAL: begin
				phase_d   = PH_FINAL;
				retries_d = retry_limit;
			end
			ACT_STATUS: phase_d = PH_IDLE;
			ACT_RETRY: retries_d = retries_q - 16'd1;
			ACT_FAIL: begin
				cack_d  = hd.ack;
				phase_d = (phase_q == PH_FINAL) ? PH_IDLE : PH_ABORT;
			end
			ACT_DRAIN_OK: begin
				done_d    = done_q + 8'd1;
				posted_d  = 1'b0;
				phase_d   = PH_CMD;
				retries_d = retry_limit;
			end
			ACT_CMD_OK: begin
				if (held_q[REQ_READ_BIT]) begin
					if (held_q[REQ_AP_BIT] && !posted_q) begin
						posted_d = 1'b1;
					end else begin
						done_d = done_q + 8'd1;
					end
				end else begin
					done_d  = done_q + 8'd1;
					wpend_d = 1'b1;
				end
				phase_d = PH_READY;
			end
			ACT_FINAL_OK: begin
				done_d   = done_q + {7'd0, posted_q};
				posted_d = 1'b0;
				wpend_d  = 1'b0;
				phase_d  = PH_IDLE;
			end
			default: ;
		endcase
	end

	// Result beats
	always_comb begin
		rp = '0;
		unique case (act)
			ACT_ISSUE_DRAIN: begin
				rp.n  = 2'd1;
				rp.r0 = cmd_res(PH_DRAIN, hd.req, hd.wdata, posted_q);
			end
			ACT_ISSUE_CMD: begin
				rp.n  = 2'd1;
				rp.r0 = cmd_res(PH_CMD, hd.req, hd.wdata, posted_q);
			end
			ACT_ISSUE_FINAL: begin
				rp.n  = 2'd1;
				rp.r0 = cmd_res(PH_FINAL, held_q, hdata_q, posted_q);
			end
			ACT_STATUS: begin
				rp.n  = 2'd1;
				rp.r0 = status_res(done_q, cack_q);
			end
			ACT_RETRY: begin
				rp.n  = 2'd1;
				rp.r0 = cmd_res(phase_q, held_q, hdata_q, posted_q);
			end
			ACT_FAIL: begin
				if (phase_q == PH_FINAL) begin
					rp.n  = 2'd1;
					rp.r0 = status_res(done_q, hd.ack);
				end
			end
			ACT_DRAIN_OK: begin
				rp.n  = 2'd2;
				rp.r0 = word_res(hd.rdata);
				rp.r1 = cmd_res(PH_CMD, held_q, hdata_q, 1'b0);
			end
			ACT_CMD_OK: begin
				if (held_q[REQ_READ_BIT] && !(held_q[REQ_AP_BIT] && !posted_q)) begin
					rp.n  = 2'd1;
					rp.r0 = word_res(hd.rdata);
				end
			end
			ACT_FINAL_OK: begin
				if (posted_q) begin
					rp.n  = 2'd2;
					rp.r0 = word_res(hd.rdata);
					rp.r1 = status_res(done_q + 8'd1, cack_q);
				end else begin
					rp.n  = 2'd1;
					rp.r0 = status_res(done_q, cack_q);
				end
			end
			default: ;
		endcase
		// Mark the final beat of this event
		if (rp.n == 2'd1) begin
			rp.r0.last = 1'b1;
		end else if (rp.n == 2'd2) begin
			rp.r1.last = 1'b1;
		end
	end

	always_comb begin
		push   = rp;
		push.n = fire ? rp.n : 2'd0;
	end

	// Hold packet state, advance on each executed event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			posted_q  <= 1'b0;
			wpend_q   <= 1'b0;
			done_q    <= '0;
			retries_q <= '0;
			held_q    <= '0;
			hdata_q   <= '0;
			mask_q    <= '0;
			cack_q    <= ACK_OK;
		end else if (fire) begin
			phase_q   <= phase_d;
			posted_q  <= posted_d;
			wpend_q   <= wpend_d;
			done_q    <= done_d;
			retries_q <= retries_d;
			held_q    <= held_d;
			hdata_q   <= hdata_d;
			mask_q    <= mask_d;
			cack_q    <= cack_d;
		end
	end

	a_retry_dec: assert property (@(posedge clk) disable iff (!arst_n)
		fire && act == ACT_RETRY |=> retries_q == $past(retries_q) - 16'd1)
		else $error("retry did not consume one attempt");

	a_reject_abort: assert property (@(posedge clk) disable iff (!arst_n)
		fire && act == ACT_REJECT |=> phase_q == PH_ABORT && cack_q == ACK_ERR)
		else $error("match-value request did not abort with error");

	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n == 2'd2 |-> push.r1.last && !push.r0.last) and
		(push.n == 2'd1 |-> push.r0.last))
		else $error("last flag not on final beat of an event");

	a_no_push_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |-> push.n == 2'd0)
		else $error("results pushed without an executed event");

endmodule

[sv/swd_ts_resq.sv]
// ----------------------------------------------------------------------------
// SWD transfer sequencer result queue
// Takes up to two result beats per cycle and drives them out one at a time.
// ----------------------------------------------------------------------------
module swd_ts_resq #(
	parameter int unsigned DEPTH = swd_ts_pkg::RESQ_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  swd_ts_pkg::res_push_t push,
	output logic                  room,
	swd_ts_res_if.source          res
);
	import swd_ts_pkg::*;

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	res_t          mem_q [DEPTH];
	res_t          hd;
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_pop;
	logic [PW-1:0] wr_ptr_nx;

	assign room      = (cnt_q <= CW'(DEPTH - 2));
	assign do_pop    = res.valid && res.ready;
	assign wr_ptr_nx = wr_ptr_q + 1'b1;
	assign hd        = mem_q[rd_ptr_q];

	// Drive the head beat
	always_comb begin
		res.valid          = (cnt_q != '0);
		res.kind           = hd.kind;
		res.wire_request   = hd.wire_request;
		res.want_read_data = hd.want_read_data;
		res.data_word      = hd.data_word;
		res.completed      = hd.completed;
		res.status_ack     = hd.status_ack;
		res.last           = hd.last;
	end

	// Store pushed beats
	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_ptr_nx] <= push.r1;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(push.n);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(push.n) - CW'(do_pop);
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |-> room)
		else $error("result queue pushed without room");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("result queue count out of range");

endmodule

[sv/swd_transfer_sequencer.sv]
// ----------------------------------------------------------------------------
// SWD transfer sequencer
// Turns host transfer events into SWD wire commands, responses and status.
// ----------------------------------------------------------------------------
// Usage:
//  evt carries one event per beat: packet begin, transfer request, packet end
//  or a wire acknowledge with its read word. res carries result beats: wire
//  commands, response read words and the packet status; last marks the final
//  beat caused by one event (most events cause none or one, a few cause two).
//  cfg_we/cfg_wdata load retry_limit; write it only while the block is idle.
//  An accepted event waits in the event queue; the packet state machine takes
//  it from there and writes its results into the registered result queue,
//  which offers them on res. Throughput: one event per cycle while the result
//  queue has room; the packet state machine decides one event per cycle, and
//  an event with two results holds the result port for both of its beats.
//  The state machine runs only when the result queue has two free slots.
//  When res stalls, the result queue fills, then the event queue, and evt
//  ready drops; nothing is lost. Reset empties both queues, leaves the
//  sequencer idle outside a packet and clears retry_limit to zero.
// ----------------------------------------------------------------------------
module swd_transfer_sequencer #(
	parameter int unsigned EVQ_DEPTH  = swd_ts_pkg::EVQ_DEPTH,
	parameter int unsigned RESQ_DEPTH = swd_ts_pkg::RESQ_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	swd_ts_evt_if.sink  evt,
	swd_ts_res_if.source res,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);
	import swd_ts_pkg::*;

	logic        hd_valid;
	ev_t         hd;
	logic        pop;
	logic        room;
	res_push_t   push;
	logic [15:0] retry_limit_q;

	// Hold the retry limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q <= '0;
		end else if (cfg_we) begin
			retry_limit_q <= cfg_wdata;
		end
	end

	swd_ts_front #(.DEPTH(EVQ_DEPTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.evt      (evt),
		.hd_valid (hd_valid),
		.hd       (hd),
		.pop      (pop)
	);

	swd_ts_exec u_exec (
		.clk         (clk),
		.arst_n      (arst_n),
		.hd_valid    (hd_valid),
		.hd          (hd),
		.pop         (pop),
		.room        (room),
		.retry_limit (retry_limit_q),
		.push        (push)
	);

	swd_ts_resq #(.DEPTH(RESQ_DEPTH)) u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.res    (res)
	);

endmodule

[bench/swd_ts_result_check.sv]
// ----------------------------------------------------------------------------
// SWD transfer sequencer result checker
// Watches the event and result channels, tracks the packet state of the
// sequencer, predicts every result beat and compares it field by field.
// ----------------------------------------------------------------------------
module swd_ts_result_check (
	input  logic        clk,
	input  logic        arst_n,
	swd_ts_evt_if       evt,
	swd_ts_res_if       res,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	output int unsigned pending,
	output int unsigned failures
);
	import swd_ts_pkg::*;

	// Shadow copy of the sequencer state and its retry setting
	logic [15:0] retry_setting = '0;
	phase_t      phase         = PH_IDLE;
	logic        posted_read   = 1'b0;
	logic        write_pending = 1'b0;
	logic [7:0]  done_count    = '0;
	logic [15:0] retries_left  = '0;
	logic [7:0]  held_request  = '0;
	logic [31:0] held_data     = '0;
	logic [31:0] mask_word     = '0;
	ack_t        packet_ack    = ACK_OK;

	res_t        expected_beats[$];
	int unsigned mismatch_count = 0;

	assign failures = mismatch_count;

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t mismatch: %s got %h expected %h", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic push_beat(kind_t k, logic [3:0] rq, logic want, logic [31:0] data,
		logic [7:0] cnt, ack_t st);
		res_t b;
		b.kind           = k;
		b.wire_request   = rq;
		b.want_read_data = want;
		b.data_word      = data;
		b.completed      = cnt;
		b.status_ack     = st;
		b.last           = 1'b0;
		expected_beats.push_back(b);
	endtask

	task automatic push_status();
		push_beat(KIND_STATUS, 4'h0, 1'b0, 32'h0, done_count, packet_ack);
	endtask

	task automatic push_word(logic [31:0] w);
		push_beat(KIND_WORD, 4'h0, 1'b0, w, 8'h0, ACK_OK);
	endtask

	// Emit the wire command that belongs to the current busy phase
	task automatic push_command();
		if (phase == PH_DRAIN) begin
			push_beat(KIND_CMD, RDBUFF_NIBBLE, 1'b1, 32'h0, 8'h0, ACK_OK);
		end else if (phase == PH_FINAL) begin
			push_beat(KIND_CMD, RDBUFF_NIBBLE, posted_read, 32'h0, 8'h0, ACK_OK);
		end else if (held_request[REQ_READ_BIT]) begin
			push_beat(KIND_CMD, held_request[3:0],
				!(held_request[REQ_AP_BIT] && !posted_read), 32'h0, 8'h0, ACK_OK);
		end else begin
			push_beat(KIND_CMD, held_request[3:0], 1'b0, held_data, 8'h0, ACK_OK);
		end
	endtask

	// Enter a busy phase with a fresh retry budget
	task automatic issue(phase_t ph);
		phase        = ph;
		retries_left = retry_setting;
		push_command();
	endtask

	// Advance the shadow state by one event and queue the beats it causes
	task automatic sequence_event(op_t op, logic [7:0] rb, logic [31:0] wd, ack_t ack,
		logic [31:0] rd);
		int unsigned before_n;
		res_t        tail;
		before_n = expected_beats.size();
		case (op)
			OP_BEGIN: begin
				phase         = PH_READY;
				posted_read   = 1'b0;
				write_pending = 1'b0;
				done_count    = '0;
				packet_ack    = ACK_OK;
			end
			OP_REQ: begin
				if (phase == PH_READY) begin
					if (rb[REQ_MVAL_BIT]) begin
						packet_ack = ACK_ERR;
						phase      = PH_ABORT;
					end else begin
						held_request = rb;
						held_data    = wd;
						if (rb[REQ_READ_BIT])
							write_pending = 1'b0;
						if (!rb[REQ_READ_BIT] && rb[REQ_MMASK_BIT]) begin
							mask_word  = wd;
							done_count = done_count + 8'd1;
						end else if (posted_read && !(rb[REQ_READ_BIT] && rb[REQ_AP_BIT])) begin
							issue(PH_DRAIN);
						end else begin
							issue(PH_CMD);
						end
					end
				end
			end
			OP_END: begin
				if (phase == PH_READY && (posted_read || write_pending)) begin
					issue(PH_FINAL);
				end else if (phase == PH_READY || phase == PH_IDLE || phase == PH_ABORT) begin
					push_status();
					phase = PH_IDLE;
				end
			end
			default: begin
				if (phase == PH_DRAIN || phase == PH_CMD || phase == PH_FINAL) begin
					if (ack == ACK_WAIT && retries_left != 0) begin
						retries_left = retries_left - 16'd1;
						push_command();
					end else if (ack != ACK_OK) begin
						packet_ack = ack;
						if (phase == PH_FINAL) begin
							push_status();
							phase = PH_IDLE;
						end else begin
							phase = PH_ABORT;
						end
					end else if (phase == PH_DRAIN) begin
						push_word(rd);
						done_count  = done_count + 8'd1;
						posted_read = 1'b0;
						issue(PH_CMD);
					end else if (phase == PH_CMD) begin
						if (held_request[REQ_READ_BIT]) begin
							if (held_request[REQ_AP_BIT] && !posted_read) begin
								posted_read = 1'b1;
							end else begin
								push_word(rd);
								done_count = done_count + 8'd1;
							end
						end else begin
							done_count    = done_count + 8'd1;
							write_pending = 1'b1;
						end
						phase = PH_READY;
					end else begin
						if (posted_read) begin
							push_word(rd);
							done_count  = done_count + 8'd1;
							posted_read = 1'b0;
						end
						write_pending = 1'b0;
						push_status();
						phase = PH_IDLE;
					end
				end
			end
		endcase
		// Mark the final beat of this event
		if (expected_beats.size() > before_n) begin
			tail      = expected_beats.pop_back();
			tail.last = 1'b1;
			expected_beats.push_back(tail);
		end
	endtask

	// Compare result beats, then fold in the accepted event
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			retry_setting = '0;
			phase         = PH_IDLE;
			posted_read   = 1'b0;
			write_pending = 1'b0;
			done_count    = '0;
			retries_left  = '0;
			held_request  = '0;
			held_data     = '0;
			mask_word     = '0;
			packet_ack    = ACK_OK;
			expected_beats.delete();
			pending = 0;
		end else begin
			if (cfg_we)
				retry_setting = cfg_wdata;
			if (res.valid && res.ready) begin
				if (expected_beats.size() == 0) begin
					report("result beat with nothing expected, kind", 32'(res.kind), 32'h0);
				end else begin
					want = expected_beats.pop_front();
					if (res.kind !== want.kind)
						report("kind", 32'(res.kind), 32'(want.kind));
					if (res.wire_request !== want.wire_request)
						report("wire_request", 32'(res.wire_request),
							32'(want.wire_request));
					if (res.want_read_data !== want.want_read_data)
						report("want_read_data", 32'(res.want_read_data),
							32'(want.want_read_data));
					if (res.data_word !== want.data_word)
						report("data_word", res.data_word, want.data_word);
					if (res.completed !== want.completed)
						report("completed", 32'(res.completed), 32'(want.completed));
					if (res.status_ack !== want.status_ack)
						report("status_ack", 32'(res.status_ack), 32'(want.status_ack));
					if (res.last !== want.last)
						report("last", 32'(res.last), 32'(want.last));
				end
			end
			if (evt.valid && evt.ready)
				sequence_event(op_t'(evt.op), evt.request_byte, evt.write_data,
					ack_t'(evt.wire_ack), evt.read_data);
			pending = expected_beats.size();
		end
	end

endmodule

[bench/swd_transfer_sequencer_test.sv]
// ----------------------------------------------------------------------------
// SWD transfer sequencer testbench
// Drives transfer packets, wire acknowledges and retry settings into the
// sequencer with random idling on both channels; a checker beside the block
// predicts and compares every result beat.
// ----------------------------------------------------------------------------
module swd_transfer_sequencer_test;
	import swd_ts_pkg::*;

	localparam int unsigned STALL_LIMIT = 400;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	int unsigned pending;
	int unsigned failures;

	// Stimulus knobs shared by the driving processes
	int unsigned gap_rate      = 15;
	bit          quiet         = 1'b0;
	int unsigned items         = 0;
	logic [15:0] retry_written = '0;

	swd_ts_evt_if evt ();
	swd_ts_res_if res ();

	swd_transfer_sequencer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	swd_ts_result_check result_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pending   (pending),
		.failures  (failures)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Stall the result channel in bursts
	initial begin
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet && gap_rate != 0 && $urandom_range(0, 99) < gap_rate) begin
				res.ready <= 1'b0;
				repeat ($urandom_range(0, 8)) @(negedge clk);
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	// End the run when nothing moves for too long
	initial begin
		int unsigned idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((evt.valid && evt.ready) || (res.valid && res.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("stalled for %0d cycles with %0d beats outstanding", idle_cycles, pending);
				$display("swd_transfer_sequencer_test: FAIL");
				$finish;
			end
		end
	end

	// Offer one event beat and hold it until accepted; returns at a falling edge
	task automatic send_event(op_t op, logic [7:0] rb, logic [31:0] wd, ack_t ack,
		logic [31:0] rd);
		if (!quiet && gap_rate != 0 && $urandom_range(0, 99) < gap_rate) begin
			evt.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		evt.op           <= op;
		evt.request_byte <= rb;
		evt.write_data   <= wd;
		evt.wire_ack     <= ack;
		evt.read_data    <= rd;
		evt.valid        <= 1'b1;
		do
			@(posedge clk);
		while (!evt.ready);
		@(negedge clk);
		items++;
	endtask

	task automatic send_ack(ack_t a);
		send_event(OP_ACK, 8'($urandom), $urandom, a, $urandom);
	endtask

	task automatic send_plain(op_t op);
		send_event(op, 8'($urandom), $urandom, ack_t'($urandom_range(0, 3)), $urandom);
	endtask

	// Drop valid, wait for all results, then let the block go quiet
	task automatic settle();
		evt.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_retry_limit(logic [15:0] v);
		cfg_wdata     <= v;
		cfg_we        <= 1'b1;
		retry_written  = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// A few waits, mostly within the retry budget, then the closing acknowledge
	task automatic ack_round();
		int unsigned r;
		int unsigned waits;
		r = $urandom_range(0, 9);
		if (r < 6)
			waits = 0;
		else if (r < 9)
			waits = (retry_written == 0) ? 0 :
				$urandom_range(1, (retry_written < 3) ? retry_written : 3);
		else
			waits = (retry_written < 4) ? retry_written + 1 : $urandom_range(1, 4);
		repeat (waits) send_ack(ACK_WAIT);
		r = $urandom_range(0, 39);
		if (r == 0)
			send_ack(ACK_FAULT);
		else if (r == 1)
			send_ack(ACK_ERR);
		else
			send_ack(ACK_OK);
	endtask

	function automatic logic [7:0] pick_request();
		logic [7:0] rb;
		rb                = 8'($urandom);
		rb[REQ_MVAL_BIT]  = ($urandom_range(0, 29) == 0);
		rb[REQ_MMASK_BIT] = ($urandom_range(0, 5) == 0);
		return rb;
	endfunction

	// One packet: begin, transfers with their acknowledges, end and flush
	task automatic random_packet(int unsigned transfers);
		logic [7:0] rb;
		send_plain(OP_BEGIN);
		for (int unsigned i = 0; i < transfers; i++) begin
			rb = pick_request();
			send_event(OP_REQ, rb, $urandom, ack_t'($urandom_range(0, 3)), $urandom);
			if (!rb[REQ_MVAL_BIT] && !(!rb[REQ_READ_BIT] && rb[REQ_MMASK_BIT])) begin
				// end while the command is out is ignored
				if ($urandom_range(0, 19) == 0)
					send_plain(OP_END);
				ack_round();
				ack_round();
			end
		end
		// leave some packets open; the next begin abandons them
		if ($urandom_range(0, 14) != 0) begin
			send_plain(OP_END);
			ack_round();
			if ($urandom_range(0, 9) == 0)
				send_plain(OP_END);
		end
	endtask

	// Enough mask writes to wrap the completed count
	task automatic long_packet();
		logic [7:0] rb;
		send_plain(OP_BEGIN);
		repeat (300) begin
			rb                = 8'($urandom);
			rb[REQ_READ_BIT]  = 1'b0;
			rb[REQ_MVAL_BIT]  = 1'b0;
			rb[REQ_MMASK_BIT] = 1'b1;
			send_event(OP_REQ, rb, $urandom, ack_t'($urandom_range(0, 3)), $urandom);
		end
		send_plain(OP_END);
		ack_round();
	endtask

	task automatic run_phase(logic [15:0] lim, int unsigned quota, int unsigned rate,
		bit with_long, bit calm_tail);
		int unsigned start;
		settle();
		write_retry_limit(lim);
		gap_rate = rate;
		start    = items;
		if (with_long)
			long_packet();
		while (items - start < quota) begin
			if (calm_tail && items - start + 150 > quota)
				quiet = 1'b1;
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 4)) begin
					send_event(op_t'($urandom_range(0, 3)), 8'($urandom), $urandom,
						ack_t'($urandom_range(0, 3)), $urandom);
				end
			end
			random_packet($urandom_range(0, 6));
		end
	endtask

	// Walk through each special case with a retry limit of zero
	task automatic directed_cases();
		send_event(OP_END, 8'h00, 32'h0, ACK_OK, 32'h0);            // status while idle
		send_event(OP_BEGIN, 8'h00, 32'h0, ACK_OK, 32'h0);
		send_event(OP_REQ, 8'hFF, 32'hFFFFFFFF, ACK_OK, 32'h0);     // match value rejected
		send_event(OP_REQ, 8'h02, 32'h0, ACK_OK, 32'h0);            // ignored after abort
		send_event(OP_ACK, 8'h00, 32'h0, ACK_OK, 32'h0);            // no command out
		send_event(OP_END, 8'h00, 32'h0, ACK_OK, 32'h0);
		send_event(OP_BEGIN, 8'h00, 32'h0, ACK_OK, 32'h0);
		send_event(OP_REQ, 8'h03, 32'h0, ACK_OK, 32'h0);            // AP read gets posted
		send_event(OP_END, 8'h00, 32'h0, ACK_OK, 32'h0);            // command out: ignored
		send_event(OP_ACK, 8'h00, 32'h0, ACK_OK, 32'hFFFFFFFF);
		send_event(OP_REQ, 8'h23, 32'h0, ACK_OK, 32'h0);            // read with mask bit
		send_event(OP_ACK, 8'h00, 32'h0, ACK_OK, 32'h12345678);
		send_event(OP_REQ, 8'h0C, 32'hFFFFFFFF, ACK_OK, 32'h0);     // write drains first
		send_event(OP_ACK, 8'h00, 32'h0, ACK_OK, 32'h00000000);
		send_event(OP_ACK, 8'h00, 32'h0, ACK_OK, 32'h0);
		send_event(OP_REQ, 8'h21, 32'hA5A5A5A5, ACK_OK, 32'h0);     // mask stored
		send_event(OP_REQ, 8'h06, 32'h0, ACK_OK, 32'h0);
		send_event(OP_ACK, 8'h00, 32'h0, ACK_WAIT, 32'h0);          // wait, no retries
		send_event(OP_END, 8'h00, 32'h0, ACK_OK, 32'h0);
		send_event(OP_BEGIN, 8'h00, 32'h0, ACK_OK, 32'h0);
		send_event(OP_REQ, 8'hC0, 32'h00000000, ACK_OK, 32'h0);
		send_event(OP_ACK, 8'h00, 32'h0, ACK_OK, 32'h0);
		send_event(OP_END, 8'h00, 32'h0, ACK_OK, 32'h0);            // write flush
		send_event(OP_ACK, 8'h00, 32'h0, ACK_FAULT, 32'h0);         // flush fails
		send_event(OP_BEGIN, 8'h00, 32'h0, ACK_OK, 32'h0);
		send_event(OP_REQ, 8'h01, 32'h0, ACK_OK, 32'h0);
		send_event(OP_BEGIN, 8'h00, 32'h0, ACK_OK, 32'h0);          // abandon the command
		send_event(OP_END, 8'h00, 32'h0, ACK_OK, 32'h0);
	endtask

	initial begin
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_wdata        = '0;
		evt.valid        = 1'b0;
		evt.op           = OP_BEGIN;
		evt.request_byte = '0;
		evt.write_data   = '0;
		evt.wire_ack     = ACK_OK;
		evt.read_data    = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_retry_limit(16'd0);
		directed_cases();

		run_phase(16'd3, 240, 20, 1'b0, 1'b0);
		run_phase(16'hFFFF, 240, 0, 1'b0, 1'b0);
		run_phase(16'd1, 240, 35, 1'b1, 1'b0);
		run_phase(16'($urandom_range(2, 40)), 240, 10, 1'b0, 1'b0);
		run_phase(16'd0, 240, 20, 1'b0, 1'b1);

		settle();
		if (failures == 0)
			$display("swd_transfer_sequencer_test: PASS");
		else
			$display("swd_transfer_sequencer_test: FAIL");
		$finish;
	end

endmodule
